>>> src/heightmap_triangle_height_sample_core_defines.svh
// Assertion macros used by the checker file.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLE_CORE_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define HTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define HTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> src/hts_pkg.sv
// Shared types and constants of the height sampler.
package hts_pkg;

  localparam int unsigned MaxSide = 256;

  typedef enum logic [2:0] {
    RegMapSide   = 3'd0,
    RegCellSizeX = 3'd1,
    RegCellRecX  = 3'd2,
    RegCellSizeZ = 3'd3,
    RegCellRecZ  = 3'd4,
    RegGain      = 3'd5
  } hts_reg_e;

  typedef struct packed {
    logic [8:0]  side;
    logic [15:0] size_x;
    logic [23:0] recip_x;
    logic [15:0] size_z;
    logic [23:0] recip_z;
    logic [15:0] gain;
  } hts_cfg_t;

  // One queued request: a load (a_bl is the write address) or a query.
  typedef struct packed {
    logic               is_query;
    logic               ok;
    logic [15:0]        a_bl;
    logic [15:0]        a_br;
    logic [15:0]        a_tl;
    logic [15:0]        a_tr;
    logic [15:0]        fx;
    logic [15:0]        fz;
    logic signed [23:0] px;
    logic signed [23:0] pz;
    logic [7:0]         wval;
  } hts_entry_t;

endpackage

>>> src/heightmap_triangle_height_sample_core.sv
// Top level of the height-map triangle sampler.
//
// Input channel (in_valid_i / in_stall_o): one request per accepted cycle.
//   mode 0 writes sample_value at sample_index of the 64K x 8 map, no result.
//   mode 1 queries world position (pos_x, pos_z), Q15.8, one result each.
// Output channel (out_valid_o / out_stall_i): echoed position, Q18.8 height
//   (zero when outside the interior cells) and the in_range flag.
// Throughput: one request per cycle while no stall holds it; the seven-stage front
//   pipeline, a four-entry queue and the six-stage back pipeline each take one
//   request a cycle, and the two map banks serve all four corner reads per cycle.
// Path: an accepted request passes 14 register stages on its way to the output,
//   the first loaded at the accepting edge.
// A receiver stall freezes the back pipeline; the queue absorbs the front,
//   and in_stall_o rises once the queue is full and the last front stage
//   holds a request.
// Reset clears all valid state and loads the register defaults; the map
//   holds no defined content until written.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
//   write only while no request is in flight.
module heightmap_triangle_height_sample_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_mode_i,
  input  logic [15:0]        in_sample_index_i,
  input  logic [7:0]         in_sample_value_i,
  input  logic signed [23:0] in_pos_x_i,
  input  logic signed [23:0] in_pos_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_x_o,
  output logic signed [23:0] out_z_o,
  output logic signed [26:0] out_height_o,
  output logic               out_in_range_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i
);
  import hts_pkg::*;

  logic [8:0]  side_q;
  logic [15:0] sx_q, sz_q, gain_q;
  logic [23:0] rx_q, rz_q;
  hts_cfg_t    cfg;
  logic [8:0]  side_eff;

  logic       push_valid, push_ready, head_valid, pop;
  hts_entry_t push_entry, head;

  // Clamp the side into the supported range.
  always_comb begin
    priority if (side_q < 9'd2) begin
      side_eff = 9'd2;
    end else if ({2'b0, side_q} > 11'(MaxSide)) begin
      side_eff = 9'(MaxSide);
    end else begin
      side_eff = side_q;
    end
  end

  assign cfg = '{side_eff, sx_q, rx_q, sz_q, rz_q, gain_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 9'd256;
      sx_q   <= 16'd7680;
      rx_q   <= 24'd2185;
      sz_q   <= 16'd7680;
      rz_q   <= 24'd2185;
      gain_q <= 16'd5120;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMapSide:   side_q <= cfg_wdata_i[8:0];
        RegCellSizeX: sx_q   <= cfg_wdata_i[15:0];
        RegCellRecX:  rx_q   <= cfg_wdata_i;
        RegCellSizeZ: sz_q   <= cfg_wdata_i[15:0];
        RegCellRecZ:  rz_q   <= cfg_wdata_i;
        RegGain:      gain_q <= cfg_wdata_i[15:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  hts_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_stall_o, .in_mode_i, .in_sample_index_i, .in_sample_value_i,
    .in_pos_x_i, .in_pos_z_i,
    .push_valid_o(push_valid), .push_entry_o(push_entry), .push_ready_i(push_ready)
  );

  hts_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni, .push_i(push_valid), .entry_i(push_entry), .ready_o(push_ready),
    .pop_i(pop), .valid_o(head_valid), .entry_o(head)
  );

  hts_back u_back (
    .clk_i, .rst_ni, .gain_i(gain_q), .head_valid_i(head_valid), .head_i(head),
    .pop_o(pop), .out_valid_o, .out_stall_i, .out_x_o, .out_z_o, .out_height_o,
    .out_in_range_o
  );
endmodule

>>> src/hts_ram.sv
// Generic RAM: one write port, two registered read ports.
module hts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end
endmodule

>>> src/hts_front.sv
// Front pipeline: centre the position, find cell and fractions, form addresses.
module hts_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hts_pkg::hts_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_mode_i,
  input  logic [15:0]         in_sample_index_i,
  input  logic [7:0]          in_sample_value_i,
  input  logic signed [23:0]  in_pos_x_i,
  input  logic signed [23:0]  in_pos_z_i,
  output logic                push_valid_o,
  output hts_pkg::hts_entry_t push_entry_o,
  input  logic                push_ready_i
);
  import hts_pkg::*;

  typedef struct packed {
    logic               mode;
    logic [15:0]        idx;
    logic [7:0]         val;
    logic signed [23:0] px;
    logic signed [23:0] pz;
  } carry_t;

  logic [6:0] v_q;
  logic       adv;
  carry_t     c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  logic [24:0] prodx_q, prodz_q;
  logic [24:0] prodx_d, prodz_d;
  logic signed [26:0] nx_w, nz_w;
  logic [25:0] nx_q, nz_q;
  logic        neg3_q, neg4_q, neg5_q;
  logic [37:0] plx_q, phx_q, plz_q, phz_q;
  logic [37:0] plx_d, phx_d, plz_d, phz_d;
  logic [49:0] fullx, fullz;
  logic [24:0] xi_q, zi_q;
  logic [15:0] fx5_q, fz5_q, fx6_q, fz6_q;
  logic [8:0]  side_m1;
  logic [17:0] base_w;
  logic        ok6_q;
  logic [15:0] base_q;
  hts_entry_t  e_d, e_q;

  assign adv          = !v_q[6] || push_ready_i;
  assign in_stall_o   = !adv;
  assign push_valid_o = v_q[6];
  assign push_entry_o = e_q;

  assign prodx_d = cfg_i.side * cfg_i.size_x;
  assign prodz_d = cfg_i.side * cfg_i.size_z;
  assign nx_w = $signed({{2{c2_q.px[23]}}, c2_q.px, 1'b0}) + $signed({2'b00, prodx_q});
  assign nz_w = $signed({2'b00, prodz_q}) - $signed({{2{c2_q.pz[23]}}, c2_q.pz, 1'b0});
  assign plx_d = nx_q * cfg_i.recip_x[11:0];
  assign phx_d = nx_q * cfg_i.recip_x[23:12];
  assign plz_d = nz_q * cfg_i.recip_z[11:0];
  assign phz_d = nz_q * cfg_i.recip_z[23:12];
  assign fullx = {12'b0, plx_q} + {phx_q, 12'b0};
  assign fullz = {12'b0, plz_q} + {phz_q, 12'b0};
  assign side_m1 = cfg_i.side - 9'd1;
  assign base_w  = zi_q[8:0] * cfg_i.side + {9'b0, xi_q[8:0]};

  always_comb begin
    e_d          = '0;
    e_d.is_query = c6_q.mode;
    e_d.ok       = ok6_q;
    e_d.px       = c6_q.px;
    e_d.pz       = c6_q.pz;
    e_d.wval     = c6_q.val;
    e_d.fx       = fx6_q;
    e_d.fz       = fz6_q;
    if (c6_q.mode) begin
      e_d.a_bl = base_q;
      e_d.a_br = base_q + 16'd1;
      e_d.a_tl = base_q + {7'b0, cfg_i.side};
      e_d.a_tr = base_q + {7'b0, cfg_i.side} + 16'd1;
    end else begin
      e_d.a_bl = c6_q.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q    <= '{in_mode_i, in_sample_index_i, in_sample_value_i, in_pos_x_i, in_pos_z_i};
      c2_q    <= c1_q;
      prodx_q <= prodx_d;
      prodz_q <= prodz_d;
      c3_q    <= c2_q;
      nx_q    <= nx_w[25:0];
      nz_q    <= nz_w[25:0];
      neg3_q  <= nx_w[26] | nz_w[26];
      c4_q    <= c3_q;
      neg4_q  <= neg3_q;
      plx_q   <= plx_d;
      phx_q   <= phx_d;
      plz_q   <= plz_d;
      phz_q   <= phz_d;
      c5_q    <= c4_q;
      neg5_q  <= neg4_q;
      xi_q    <= fullx[49:25];
      zi_q    <= fullz[49:25];
      fx5_q   <= fullx[24:9];
      fz5_q   <= fullz[24:9];
      c6_q    <= c5_q;
      fx6_q   <= fx5_q;
      fz6_q   <= fz5_q;
      ok6_q   <= !neg5_q && (xi_q < {16'b0, side_m1}) && (zi_q < {16'b0, side_m1});
      base_q  <= base_w[15:0];
      e_q     <= e_d;
    end
  end
endmodule

>>> src/hts_fifo.sv
// Short request queue between front and back.
module hts_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hts_pkg::hts_entry_t entry_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hts_pkg::hts_entry_t entry_o
);
  import hts_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hts_entry_t    mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= entry_i;
    end
  end
endmodule

>>> src/hts_back.sv
// Back pipeline: map access, triangle fix-up, bilinear blend, gain, result.
module hts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         gain_i,
  input  logic                head_valid_i,
  input  hts_pkg::hts_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [23:0]  out_x_o,
  output logic signed [23:0]  out_z_o,
  output logic signed [26:0]  out_height_o,
  output logic                out_in_range_o
);
  import hts_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [15:0]        fx;
    logic [15:0]        fz;
    logic signed [23:0] px;
    logic signed [23:0] pz;
  } meta_t;

  logic [5:0] v_q;
  logic       badv;
  meta_t      m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [7:0] rd_bl, rd_br, rd_tl, rd_tr;

  logic signed [10:0] s_bl, s_br, s_tl, s_tr, bl_d, tr_d;
  logic signed [10:0] bl2_q, br2_q, tl2_q, tr2_q;
  logic [16:0]        sumf;
  logic signed [11:0] dt, db;
  logic signed [29:0] tp, bp, top_q, bot_q;
  logic signed [30:0] dtb;
  logic signed [48:0] hp, h_q;
  logic [47:0]        hc;
  logic [47:0]        phh_d, phh_q;
  logic [31:0]        phl_d, phl_q;
  logic [64:0]        sum;
  logic [32:0]        q;

  assign badv  = !v_q[5] || !out_stall_i;
  assign pop_o = head_valid_i && badv;

  hts_ram #(.Width(8), .Depth(65536)) u_ram_lo (
    .clk_i, .we_i(pop_o && !head_i.is_query), .waddr_i(head_i.a_bl),
    .wdata_i(head_i.wval), .re_i(badv), .raddr0_i(head_i.a_bl), .raddr1_i(head_i.a_br),
    .rdata0_o(rd_bl), .rdata1_o(rd_br)
  );
  hts_ram #(.Width(8), .Depth(65536)) u_ram_hi (
    .clk_i, .we_i(pop_o && !head_i.is_query), .waddr_i(head_i.a_bl),
    .wdata_i(head_i.wval), .re_i(badv), .raddr0_i(head_i.a_tl), .raddr1_i(head_i.a_tr),
    .rdata0_o(rd_tl), .rdata1_o(rd_tr)
  );

  assign s_bl = $signed({3'b0, rd_bl});
  assign s_br = $signed({3'b0, rd_br});
  assign s_tl = $signed({3'b0, rd_tl});
  assign s_tr = $signed({3'b0, rd_tr});
  assign sumf = {1'b0, m1_q.fx} + {1'b0, m1_q.fz};

  // Lower triangle rebuilds tr, upper triangle rebuilds bl.
  always_comb begin
    bl_d = s_bl;
    tr_d = s_tr;
    if (!sumf[16]) begin
      tr_d = s_tl + s_br - s_bl;
    end else begin
      bl_d = s_tl + s_br - s_tr;
    end
  end

  assign dt  = {tr2_q[10], tr2_q} - {tl2_q[10], tl2_q};
  assign db  = {br2_q[10], br2_q} - {bl2_q[10], bl2_q};
  assign tp  = dt * $signed({1'b0, m2_q.fx});
  assign bp  = db * $signed({1'b0, m2_q.fx});
  assign dtb = {top_q[29], top_q} - {bot_q[29], bot_q};
  assign hp  = dtb * $signed({1'b0, m3_q.fz});
  assign hc  = h_q[48] ? '0 : h_q[47:0];
  assign phh_d = hc[47:16] * gain_i;
  assign phl_d = hc[15:0] * gain_i;
  assign sum = {1'b0, phh_q, 16'b0} + {33'b0, phl_q};
  assign q   = sum[64:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (badv) begin
      v_q <= {v_q[4:0], pop_o && head_i.is_query};
    end
  end

  always_ff @(posedge clk_i) begin
    if (badv) begin
      m1_q  <= '{head_i.ok, head_i.fx, head_i.fz, head_i.px, head_i.pz};
      m2_q  <= m1_q;
      bl2_q <= bl_d;
      br2_q <= s_br;
      tl2_q <= s_tl;
      tr2_q <= tr_d;
      m3_q  <= m2_q;
      top_q <= {{3{tl2_q[10]}}, tl2_q, 16'b0} + tp;
      bot_q <= {{3{bl2_q[10]}}, bl2_q, 16'b0} + bp;
      m4_q  <= m3_q;
      h_q   <= {{3{bot_q[29]}}, bot_q, 16'b0} + hp;
      m5_q  <= m4_q;
      phh_q <= phh_d;
      phl_q <= phl_d;
      out_x_o        <= m5_q.px;
      out_z_o        <= m5_q.pz;
      out_in_range_o <= m5_q.ok;
      if (!m5_q.ok) begin
        out_height_o <= '0;
      end else if (|q[32:26]) begin
        out_height_o <= 27'sh3FFFFFF;
      end else begin
        out_height_o <= $signed(q[26:0]);
      end
    end
  end

  assign out_valid_o = v_q[5];
endmodule

>>> src/hts_checker.sv
// Port-level checks of the sampler, bound to the top level.
`include "heightmap_triangle_height_sample_core_defines.svh"

module hts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [26:0] out_height_o,
  input logic               out_in_range_o
);
  // a stalled result stays valid
  `HTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // outside points report zero height
  `HTS_ASSERT_NOW(a_out_zero, out_valid_o && !out_in_range_o, out_height_o == 27'sd0)
  // height is never negative
  `HTS_ASSERT_NOW(a_out_sign, out_valid_o, !out_height_o[26])
endmodule

bind heightmap_triangle_height_sample_core hts_checker u_hts_checker (.*);

>>> tb/tb_heightmap_triangle_height_sample_core.sv
// Testbench of the height-map triangle sampler: directed and random requests vs a predictor.
`timescale 1ns / 100ps

module tb_heightmap_triangle_height_sample_core;
  import hts_pkg::*;

  // Result of locating a position on the grid: the cell's corner addresses
  // (bottom-left, bottom-right, top-left, top-right) and the Q0.16 offsets.
  typedef struct {
    bit          ok;
    bit [15:0]   addr[4];
    longint      fx;
    longint      fz;
  } cell_hit_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] z;
    logic signed [26:0] height;
    logic               in_range;
  } height_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic               in_mode = 1'b0;
  logic [15:0]        in_sample_index = '0;
  logic [7:0]         in_sample_value = '0;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_z = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic signed [23:0] out_x_o;
  logic signed [23:0] out_z_o;
  logic signed [26:0] out_height_o;
  logic               out_in_range_o;
  logic               cfg_we = 1'b0;
  hts_reg_e           cfg_idx = RegMapSide;
  logic [23:0]        cfg_wdata = '0;

  // Predictor state: configuration copy and map contents with a written mask.
  logic [8:0]  side_q = 9'd256;
  logic [15:0] size_x_q = 16'd7680;
  logic [23:0] recip_x_q = 24'd2185;
  logic [15:0] size_z_q = 16'd7680;
  logic [23:0] recip_z_q = 24'd2185;
  logic [15:0] gain_q = 16'd5120;
  bit [7:0]    sample_mem[65536];
  bit          sample_written[65536];

  height_result_t pending_heights[$];
  int          mismatch_count = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  heightmap_triangle_height_sample_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .in_mode_i        (in_mode),
    .in_sample_index_i(in_sample_index),
    .in_sample_value_i(in_sample_value),
    .in_pos_x_i       (in_pos_x),
    .in_pos_z_i       (in_pos_z),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .out_x_o          (out_x_o),
    .out_z_o          (out_z_o),
    .out_height_o     (out_height_o),
    .out_in_range_o   (out_in_range_o),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Effective side: the register saturates to 2..MaxSide.
  function automatic longint eff_side();
    if (side_q < 9'd2) return 2;
    if (side_q > MaxSide) return MaxSide;
    return longint'(side_q);
  endfunction

  // Center the grid, scale by the reciprocal spacing and split into index and fraction.
  function automatic cell_hit_t locate_cell(input logic signed [23:0] px,
                                            input logic signed [23:0] pz);
    cell_hit_t c;
    longint    side, nx, nz, ux, uz, xi, zi, base;
    side = eff_side();
    c.ok = 1'b0;
    c.fx = 0;
    c.fz = 0;
    foreach (c.addr[i]) c.addr[i] = '0;
    nx = 2 * longint'(px) + side * longint'(size_x_q);
    nz = -2 * longint'(pz) + side * longint'(size_z_q);
    // Negative centered offsets are outside: floor, not truncation.
    if (nx < 0 || nz < 0) return c;
    ux = (nx * longint'(recip_x_q)) >>> 9;
    uz = (nz * longint'(recip_z_q)) >>> 9;
    xi = ux >>> 16;
    zi = uz >>> 16;
    if (xi >= side - 1 || zi >= side - 1) return c;
    c.ok = 1'b1;
    c.fx = ux & 64'hFFFF;
    c.fz = uz & 64'hFFFF;
    base = zi * side + xi;
    c.addr[0] = base[15:0];
    c.addr[1] = 16'(base + 1);
    c.addr[2] = 16'(base + side);
    c.addr[3] = 16'(base + side + 1);
    return c;
  endfunction

  // Triangle-corrected bilinear height, scaled by the gain.
  function automatic height_result_t predict_height(input logic signed [23:0] px,
                                                    input logic signed [23:0] pz);
    height_result_t r;
    cell_hit_t      c;
    longint         bl, br, tl, tr, top, bot, h;
    c = locate_cell(px, pz);
    r.x = px;
    r.z = pz;
    r.height = '0;
    r.in_range = c.ok;
    if (!c.ok) return r;
    bl = sample_mem[c.addr[0]];
    br = sample_mem[c.addr[1]];
    tl = sample_mem[c.addr[2]];
    tr = sample_mem[c.addr[3]];
    // Replace the corner opposite the triangle holding the point.
    if (c.fz + c.fx < 65536) tr = tl + (br - bl);
    else bl = tl + (br - tr);
    top = tl * (65536 - c.fx) + tr * c.fx;
    bot = bl * (65536 - c.fx) + br * c.fx;
    h = bot * (65536 - c.fz) + top * c.fz;
    if (h < 0) h = 0;
    h = (h * longint'(gain_q)) >>> 32;
    if (h > 67108863) h = 67108863;
    r.height = h[26:0];
    return r;
  endfunction

  // Send one request, hold it until accepted, update the predictor, then maybe idle.
  task automatic send_request(input bit mode, input logic [15:0] idx, input logic [7:0] val,
                              input logic signed [23:0] px, input logic signed [23:0] pz);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_sample_index <= idx;
    in_sample_value <= val;
    in_pos_x <= px;
    in_pos_z <= pz;
    do @(posedge clk_i); while (in_stall_o);
    if (!mode) begin
      sample_mem[idx] = val;
      sample_written[idx] = 1'b1;
    end else begin
      pending_heights.insert(pending_heights.size(), predict_height(px, pz));
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Load any unwritten corner first so the query never reads undefined samples.
  task automatic query_height(input logic signed [23:0] px, input logic signed [23:0] pz);
    cell_hit_t c;
    c = locate_cell(px, pz);
    if (c.ok) begin
      foreach (c.addr[i]) begin
        if (!sample_written[c.addr[i]])
          send_request(1'b0, c.addr[i], 8'($urandom), '0, '0);
      end
    end
    send_request(1'b1, 16'($urandom), 8'($urandom), px, pz);
  endtask

  // Drop valid and wait until every expected height has come back.
  task automatic drain_heights();
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write all six registers back to back while the block is idle.
  task automatic program_grid(input logic [8:0] side, input logic [15:0] sx,
                              input logic [23:0] rx, input logic [15:0] sz,
                              input logic [23:0] rz, input logic [15:0] gain);
    hts_reg_e    regs[6];
    logic [23:0] vals[6];
    regs = '{RegMapSide, RegCellSizeX, RegCellRecX, RegCellSizeZ, RegCellRecZ, RegGain};
    vals = '{24'(side), 24'(sx), rx, 24'(sz), rz, 24'(gain)};
    drain_heights();
    foreach (regs[i]) begin
      cfg_we <= 1'b1;
      cfg_idx <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    side_q = side;
    size_x_q = sx;
    recip_x_q = rx;
    size_z_q = sz;
    recip_z_q = rz;
    gain_q = gain;
  endtask

  function automatic logic [23:0] recip_for(input logic [15:0] size);
    longint r;
    r = (longint'(1) << 24) / longint'(size);
    return (r > 24'hFFFFFF) ? 24'hFFFFFF : r[23:0];
  endfunction

  // Position within the map span on one axis, plus a margin of two either side, clamped to 24 bits.
  function automatic logic signed [23:0] pos_in_span(input logic [15:0] size);
    longint span, p;
    span = eff_side() * longint'(size);
    p = longint'($urandom_range(0, 32'(span + 4))) - span / 2 - 2;
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[23:0];
  endfunction

  // Mostly well-formed queries inside the map; the rest noise loads and wild positions.
  task automatic run_random(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        send_request(1'b0, 16'($urandom), 8'($urandom), 24'($urandom), 24'($urandom));
      else if (pick == 1)
        query_height(24'($urandom), 24'($urandom));
      else
        query_height(pos_in_span(size_x_q), pos_in_span(size_z_q));
    end
  endtask

  // Default registers: center, corners, far edge, negative offsets, extremes.
  task automatic test_default_grid();
    query_height(24'sd0, 24'sd0);
    query_height(-24'sd983040, 24'sd983040);
    query_height(24'sd983039, -24'sd983039);
    query_height(-24'sd983041, 24'sd0);
    query_height(24'sd0, 24'sd983041);
    query_height(24'sh7FFFFF, 24'sh7FFFFF);
    query_height(24'sh800000, 24'sh800000);
    query_height(24'sh7FFFFF, 24'sh800000);
    query_height(24'sh800000, 24'sh7FFFFF);
    query_height(24'sd1000, -24'sd2000);
  endtask

  // Smallest map: both triangles and the diagonal between them.
  task automatic test_triangles();
    program_grid(9'd2, 16'd256, 24'd65536, 16'd256, 24'd65536, 16'd256);
    send_request(1'b0, 16'd0, 8'd0, '0, '0);
    send_request(1'b0, 16'd1, 8'd255, '0, '0);
    send_request(1'b0, 16'd2, 8'd255, '0, '0);
    send_request(1'b0, 16'd3, 8'd17, '0, '0);
    query_height(-24'sd250, 24'sd250);
    query_height(-24'sd10, 24'sd10);
    query_height(-24'sd128, 24'sd128);
    query_height(-24'sd200, 24'sd60);
    query_height(-24'sd256, -24'sd256);
    query_height(24'sd0, 24'sd0);
  endtask

  // Walk through register settings, the extremes among them.
  task automatic test_register_sweep();
    logic [15:0] sx, sz;
    idle_on = 1'b1;
    program_grid(9'd0, 16'd1, 24'hFFFFFF, 16'd1, 24'hFFFFFF, 16'hFFFF);
    run_random(80);
    program_grid(9'd1, 16'd300, recip_for(16'd300), 16'd500, recip_for(16'd500), 16'd0);
    run_random(60);
    program_grid(9'd511, 16'hFFFF, 24'd256, 16'hFFFF, 24'd256, 16'd1);
    run_random(30);
    program_grid(9'd257, 16'd7680, 24'd2185, 16'd3840, 24'd4369, 16'd5120);
    run_random(30);
    repeat (3) begin
      idle_on = ($urandom_range(0, 3) != 0);
      sx = 16'($urandom_range(16, 2048));
      sz = 16'($urandom_range(16, 2048));
      program_grid(9'($urandom_range(3, 16)), sx, recip_for(sx), sz, recip_for(sz),
                   16'($urandom));
      run_random(90);
    end
    // Reciprocals that do not match the spacing.
    program_grid(9'($urandom_range(2, 12)), 16'($urandom_range(1, 4096)), 24'($urandom),
                 16'($urandom_range(1, 4096)), 24'($urandom), 16'($urandom));
    run_random(80);
  endtask

  // Hold the sender until all results are back, then resume.
  task automatic test_drain_pause();
    idle_on = 1'b1;
    program_grid(9'd8, 16'd512, recip_for(16'd512), 16'd768, recip_for(16'd768), 16'd700);
    run_random(50);
    drain_heights();
    run_random(50);
  endtask

  // Full rate on both sides to close the run.
  task automatic test_full_rate();
    idle_on = 1'b0;
    program_grid(9'd6, 16'd1024, recip_for(16'd1024), 16'd1024, recip_for(16'd1024),
                 16'd2048);
    run_random(150);
    drain_heights();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_grid();
    test_triangles();
    test_register_sweep();
    test_drain_pause();
    test_full_rate();
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Receiver stall in random bursts; none once idling is switched off.
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expected height.
  always @(posedge clk_i) begin
    height_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_heights.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: x=%0d z=%0d height=%0d in_range=%0b",
                   out_x_o, out_z_o, out_height_o, out_in_range_o);
      end else begin
        want = pending_heights.pop_front();
        if (out_x_o !== want.x || out_z_o !== want.z || out_height_o !== want.height ||
            out_in_range_o !== want.in_range) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"height mismatch: expected x=%0d z=%0d h=%0d r=%0b, ",
                      "got x=%0d z=%0d h=%0d r=%0b"},
                     want.x, want.z, want.height, want.in_range,
                     out_x_o, out_z_o, out_height_o, out_in_range_o);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+src
src/hts_pkg.sv
src/hts_ram.sv
src/hts_front.sv
src/hts_fifo.sv
src/hts_back.sv
src/heightmap_triangle_height_sample_core.sv
src/hts_checker.sv
tb/tb_heightmap_triangle_height_sample_core.sv
